// ----- design/sscd_pkg.sv -----
// Shared types and constants for the swept sphere collision test block.
`default_nettype none
package sscd_pkg;

  localparam int TS_W      = 32;
  localparam int MS_W      = 16;
  localparam int CFG_IDX_W = 1;
  localparam int CNT_W     = 6;

  localparam logic [CFG_IDX_W-1:0] CFG_TIMESTEP     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SPEED_SQ = 1'b1;

  localparam logic [TS_W-1:0] TIMESTEP_RST     = 32'd65536;
  localparam logic [MS_W-1:0] MIN_SPEED_SQ_RST = 16'd1;

  // Last count of each sequenced phase.
  localparam logic [CNT_W-1:0] LAST_MAC  = 6'd3;
  localparam logic [CNT_W-1:0] LAST_DIST = 6'd4;
  localparam logic [CNT_W-1:0] LAST_DIV  = 6'(TS_W - 1);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DOT,
    ST_VV,
    ST_DIVPREP,
    ST_DIV,
    ST_TSEL,
    ST_CMUL,
    ST_DIST,
    ST_OUT
  } state_e;

  typedef struct packed {
    state_e           phase;
    logic [CNT_W-1:0] cnt;
    logic             store_first;
    logic             start;
    logic             out_load;
  } cmd_t;

  typedef struct packed {
    logic div_skip;
  } status_t;

endpackage
`default_nettype wire

// ----- design/sscd_if.sv -----
// Input and output channel interfaces of the swept sphere collision test block.
`default_nettype none
interface sscd_in_if #(parameter int COORD_WIDTH = 32) ();
  logic                          valid;
  logic                          ready;
  logic                          second_of_pair;
  logic signed [COORD_WIDTH-1:0] pos_x;
  logic signed [COORD_WIDTH-1:0] pos_y;
  logic signed [COORD_WIDTH-1:0] pos_z;
  logic signed [COORD_WIDTH-1:0] vel_x;
  logic signed [COORD_WIDTH-1:0] vel_y;
  logic signed [COORD_WIDTH-1:0] vel_z;
  logic        [COORD_WIDTH-2:0] radius;

  modport source (output valid, second_of_pair, pos_x, pos_y, pos_z,
                  vel_x, vel_y, vel_z, radius, input ready);
  modport sink (input valid, second_of_pair, pos_x, pos_y, pos_z,
                vel_x, vel_y, vel_z, radius, output ready);
endinterface

interface sscd_out_if #(parameter int COORD_WIDTH = 32) ();
  logic                          valid;
  logic                          ready;
  logic                          hit;
  logic signed [COORD_WIDTH-1:0] contact_x;
  logic signed [COORD_WIDTH-1:0] contact_y;
  logic signed [COORD_WIDTH-1:0] contact_z;

  modport source (output valid, hit, contact_x, contact_y, contact_z, input ready);
  modport sink (input valid, hit, contact_x, contact_y, contact_z, output ready);
endinterface
`default_nettype wire

// ----- design/swept_sphere_collision_test_core.sv -----
// Swept sphere pair test: a first beat holds a sphere, a second beat yields one result.
// A first-sphere beat is only held; a second-sphere beat runs the dot product, speed
// squared, the 32-step restoring divider (skipped when the spheres do not approach fast
// enough or the quotient would overflow), the time select, the contact offsets and the
// distance test on the shared multiplier. No new beat is taken until the result has entered
// the output register, which waits while an earlier result is still held there.
`default_nettype none
module swept_sphere_collision_test_core #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  sscd_in_if.sink                              in_if,
  sscd_out_if.source                           out_if,
  input  wire logic                            cfg_we_i,
  input  wire logic [sscd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [sscd_pkg::TS_W-1:0]       cfg_data_i
);

  sscd_pkg::cmd_t    cmd;
  sscd_pkg::status_t status;

  sscd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_second_i (in_if.second_of_pair),
    .in_ready_o  (in_if.ready),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  sscd_datapath #(
    .COORD_WIDTH (COORD_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .pos_x_i     (in_if.pos_x),
    .pos_y_i     (in_if.pos_y),
    .pos_z_i     (in_if.pos_z),
    .vel_x_i     (in_if.vel_x),
    .vel_y_i     (in_if.vel_y),
    .vel_z_i     (in_if.vel_z),
    .radius_i    (in_if.radius),
    .hit_o       (out_if.hit),
    .contact_x_o (out_if.contact_x),
    .contact_y_o (out_if.contact_y),
    .contact_z_o (out_if.contact_z)
  );

endmodule
`default_nettype wire

// ----- design/sscd_ctrl.sv -----
// Sequencer for the pair test: steps the shared multiplier and divider.
`default_nettype none
module sscd_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  input  wire logic            in_second_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  input  wire sscd_pkg::status_t status_i,
  output sscd_pkg::cmd_t       cmd_o
);

  sscd_pkg::state_e                 state_q, state_d;
  logic [sscd_pkg::CNT_W-1:0]       cnt_q, cnt_d;
  logic                             out_valid_q, out_valid_d;
  logic                             accept;
  logic                             load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sscd_pkg::ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q + 1'b1;
    accept  = in_valid_i && (state_q == sscd_pkg::ST_IDLE);
    load    = 1'b0;
    case (state_q)
      sscd_pkg::ST_IDLE: begin
        cnt_d = '0;
        if (accept && in_second_i) state_d = sscd_pkg::ST_DOT;
      end
      sscd_pkg::ST_DOT: begin
        if (cnt_q == sscd_pkg::LAST_MAC) begin
          state_d = sscd_pkg::ST_VV;
          cnt_d   = '0;
        end
      end
      sscd_pkg::ST_VV: begin
        if (cnt_q == sscd_pkg::LAST_MAC) begin
          state_d = sscd_pkg::ST_DIVPREP;
          cnt_d   = '0;
        end
      end
      sscd_pkg::ST_DIVPREP: begin
        cnt_d   = '0;
        state_d = status_i.div_skip ? sscd_pkg::ST_TSEL : sscd_pkg::ST_DIV;
      end
      sscd_pkg::ST_DIV: begin
        if (cnt_q == sscd_pkg::LAST_DIV) begin
          state_d = sscd_pkg::ST_TSEL;
          cnt_d   = '0;
        end
      end
      sscd_pkg::ST_TSEL: begin
        state_d = sscd_pkg::ST_CMUL;
        cnt_d   = '0;
      end
      sscd_pkg::ST_CMUL: begin
        if (cnt_q == sscd_pkg::LAST_MAC) begin
          state_d = sscd_pkg::ST_DIST;
          cnt_d   = '0;
        end
      end
      sscd_pkg::ST_DIST: begin
        if (cnt_q == sscd_pkg::LAST_DIST) begin
          state_d = sscd_pkg::ST_OUT;
          cnt_d   = '0;
        end
      end
      sscd_pkg::ST_OUT: begin
        cnt_d = '0;
        // The previous result must have left the output register first.
        if (!out_valid_q || out_ready_i) begin
          load    = 1'b1;
          state_d = sscd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = sscd_pkg::ST_IDLE;
        cnt_d   = '0;
      end
    endcase

    if (load) out_valid_d = 1'b1;
    else if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    else out_valid_d = out_valid_q;

    cmd_o.phase       = state_q;
    cmd_o.cnt         = cnt_q;
    cmd_o.store_first = accept && !in_second_i;
    cmd_o.start       = accept && in_second_i;
    cmd_o.out_load    = load;
  end

  assign in_ready_o  = (state_q == sscd_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

// ----- design/sscd_datapath.sv -----
// Datapath: differences, shared multiplier, accumulators, divider and output register.
`default_nettype none
module sscd_datapath #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire sscd_pkg::cmd_t                cmd_i,
  output sscd_pkg::status_t                  status_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [sscd_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [sscd_pkg::TS_W-1:0]     cfg_data_i,
  input  wire logic signed [COORD_WIDTH-1:0] pos_x_i,
  input  wire logic signed [COORD_WIDTH-1:0] pos_y_i,
  input  wire logic signed [COORD_WIDTH-1:0] pos_z_i,
  input  wire logic signed [COORD_WIDTH-1:0] vel_x_i,
  input  wire logic signed [COORD_WIDTH-1:0] vel_y_i,
  input  wire logic signed [COORD_WIDTH-1:0] vel_z_i,
  input  wire logic        [COORD_WIDTH-2:0] radius_i,
  output logic                               hit_o,
  output logic signed [COORD_WIDTH-1:0]      contact_x_o,
  output logic signed [COORD_WIDTH-1:0]      contact_y_o,
  output logic signed [COORD_WIDTH-1:0]      contact_z_o
);

  localparam int CW  = COORD_WIDTH;
  localparam int SW  = CW + 2;
  localparam int OW  = (SW > sscd_pkg::TS_W + 2) ? SW : sscd_pkg::TS_W + 2;
  localparam int PW  = 2 * OW;
  localparam int AW  = 2 * CW + 2;
  localparam int NW  = AW + FRAC_BITS;
  localparam int RW  = AW + 1;
  localparam int DW  = 2 * CW + 4;
  localparam int XW  = AW + sscd_pkg::MS_W + FRAC_BITS;
  localparam int TW  = sscd_pkg::TS_W;

  logic [TW-1:0]              ts_q;
  logic [sscd_pkg::MS_W-1:0]  thr_q;

  logic signed [CW-1:0] hp_q [3];
  logic signed [CW-1:0] hv_q [3];
  logic        [CW-2:0] hr_q;

  logic signed [CW-1:0] pin [3];
  logic signed [CW-1:0] vin [3];
  logic signed [CW-1:0] dx_q [3];
  logic signed [CW-1:0] dv_q [3];
  logic signed [CW-1:0] dx_d [3];
  logic signed [CW-1:0] dv_d [3];
  logic signed [SW-1:0] c_q [3];
  logic        [CW-1:0] rs_q;

  logic signed [PW-1:0] prod_q;
  logic signed [AW-1:0] dot_q;
  logic        [AW-1:0] vv_q;
  logic        [DW-1:0] dist_q;
  logic        [2*CW-1:0] rsq_q;

  logic          go_q, ovf_q;
  logic [RW-1:0] rem_q;
  logic [TW-1:0] nlo_q;
  logic [TW-1:0] quo_q;
  logic [TW-1:0] t_q;

  logic [1:0] sel, isel, psel;
  logic signed [OW-1:0] mul_a, mul_b;
  logic signed [PW-1:0] mul_p;

  logic [AW-1:0] nd;
  logic [NW-1:0] num;
  logic [NW-1:0] num_hi;
  logic          go, ovf;
  logic [RW-1:0] rem_sh;

  logic signed [PW-1:0] dvt_sh;
  logic signed [PW:0]   c_sum;
  logic signed [SW-1:0] c_sat;

  logic signed [CW+3:0] ct_sum [3];
  logic signed [CW-1:0] ct_sat [3];
  logic                 hit;

  assign pin[0] = pos_x_i;
  assign pin[1] = pos_y_i;
  assign pin[2] = pos_z_i;
  assign vin[0] = vel_x_i;
  assign vin[1] = vel_y_i;
  assign vin[2] = vel_z_i;

  // Saturating component differences of the second sphere against the held one.
  always_comb begin
    logic signed [CW:0] ddx, ddv;
    for (int i = 0; i < 3; i++) begin
      ddx = {pin[i][CW-1], pin[i]} - {hp_q[i][CW-1], hp_q[i]};
      ddv = {vin[i][CW-1], vin[i]} - {hv_q[i][CW-1], hv_q[i]};
      if (ddx[CW] != ddx[CW-1]) dx_d[i] = ddx[CW] ? {1'b1, {(CW-1){1'b0}}}
                                                  : {1'b0, {(CW-1){1'b1}}};
      else dx_d[i] = ddx[CW-1:0];
      if (ddv[CW] != ddv[CW-1]) dv_d[i] = ddv[CW] ? {1'b1, {(CW-1){1'b0}}}
                                                  : {1'b0, {(CW-1){1'b1}}};
      else dv_d[i] = ddv[CW-1:0];
    end
  end

  assign sel  = cmd_i.cnt[1:0];
  assign isel = (sel == 2'd3) ? 2'd2 : sel;
  assign psel = sel - 2'd1;

  // Operand select for the one shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.phase)
      sscd_pkg::ST_DOT: begin
        mul_a = {{(OW-CW){dx_q[isel][CW-1]}}, dx_q[isel]};
        mul_b = {{(OW-CW){dv_q[isel][CW-1]}}, dv_q[isel]};
      end
      sscd_pkg::ST_VV: begin
        mul_a = {{(OW-CW){dv_q[isel][CW-1]}}, dv_q[isel]};
        mul_b = mul_a;
      end
      sscd_pkg::ST_CMUL: begin
        mul_a = {{(OW-CW){dv_q[isel][CW-1]}}, dv_q[isel]};
        mul_b = {{(OW-TW){1'b0}}, t_q};
      end
      sscd_pkg::ST_DIST: begin
        if (sel == 2'd3) begin
          mul_a = {{(OW-CW){1'b0}}, rs_q};
          mul_b = mul_a;
        end else begin
          mul_a = {{(OW-SW){c_q[isel][SW-1]}}, c_q[isel]};
          mul_b = mul_a;
        end
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Division setup: quotient of at least 2^32 only ever clamps to the timestep.
  assign nd     = AW'(-dot_q);
  assign num    = {nd, {FRAC_BITS{1'b0}}};
  assign num_hi = num >> TW;
  assign go     = (vv_q != '0) && dot_q[AW-1] &&
                  (XW'(vv_q) >= XW'({thr_q, {FRAC_BITS{1'b0}}}));
  assign ovf    = num_hi >= NW'(vv_q);
  assign status_o.div_skip = !go || ovf;

  assign rem_sh = {rem_q[RW-2:0], nlo_q[TW-1]};

  // Closest offset component, saturated to two bits beyond a coordinate.
  always_comb begin
    dvt_sh = prod_q >>> FRAC_BITS;
    c_sum  = {dvt_sh[PW-1], dvt_sh} + {{(PW+1-CW){dx_q[psel][CW-1]}}, dx_q[psel]};
    if ((&c_sum[PW:SW-1]) || !(|c_sum[PW:SW-1])) c_sat = c_sum[SW-1:0];
    else c_sat = c_sum[PW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ct_sum[i] = {{4{hp_q[i][CW-1]}}, hp_q[i]} + {{2{c_q[i][SW-1]}}, c_q[i]}
                - {{4{dx_q[i][CW-1]}}, dx_q[i]};
      if ((&ct_sum[i][CW+3:CW-1]) || !(|ct_sum[i][CW+3:CW-1]))
        ct_sat[i] = ct_sum[i][CW-1:0];
      else ct_sat[i] = ct_sum[i][CW+3] ? {1'b1, {(CW-1){1'b0}}}
                                       : {1'b0, {(CW-1){1'b1}}};
    end
  end

  assign hit = dist_q < DW'(rsq_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ts_q  <= sscd_pkg::TIMESTEP_RST;
      thr_q <= sscd_pkg::MIN_SPEED_SQ_RST;
      for (int i = 0; i < 3; i++) begin
        hp_q[i] <= '0;
        hv_q[i] <= '0;
      end
      hr_q <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          sscd_pkg::CFG_TIMESTEP:     ts_q  <= cfg_data_i;
          sscd_pkg::CFG_MIN_SPEED_SQ: thr_q <= cfg_data_i[sscd_pkg::MS_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.store_first) begin
        for (int i = 0; i < 3; i++) begin
          hp_q[i] <= pin[i];
          hv_q[i] <= vin[i];
        end
        hr_q <= radius_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_p;
    if (cmd_i.start) begin
      for (int i = 0; i < 3; i++) begin
        dx_q[i] <= dx_d[i];
        dv_q[i] <= dv_d[i];
      end
      rs_q   <= CW'(hr_q) + CW'(radius_i);
      dot_q  <= '0;
      vv_q   <= '0;
      dist_q <= '0;
    end
    case (cmd_i.phase)
      sscd_pkg::ST_DOT:
        if (sel != 2'd0) dot_q <= dot_q + prod_q[AW-1:0];
      sscd_pkg::ST_VV:
        if (sel != 2'd0) vv_q <= vv_q + prod_q[AW-1:0];
      sscd_pkg::ST_DIVPREP: begin
        go_q  <= go;
        ovf_q <= ovf;
        rem_q <= num_hi[RW-1:0];
        nlo_q <= num[TW-1:0];
        quo_q <= '0;
      end
      sscd_pkg::ST_DIV: begin
        nlo_q <= {nlo_q[TW-2:0], 1'b0};
        if (rem_sh >= RW'(vv_q)) begin
          rem_q <= rem_sh - RW'(vv_q);
          quo_q <= {quo_q[TW-2:0], 1'b1};
        end else begin
          rem_q <= rem_sh;
          quo_q <= {quo_q[TW-2:0], 1'b0};
        end
      end
      sscd_pkg::ST_TSEL: begin
        if (!go_q) t_q <= '0;
        else if (ovf_q || (quo_q > ts_q)) t_q <= ts_q;
        else t_q <= quo_q;
      end
      sscd_pkg::ST_CMUL:
        if (sel != 2'd0) c_q[psel] <= c_sat;
      sscd_pkg::ST_DIST: begin
        if (cmd_i.cnt == sscd_pkg::LAST_DIST) rsq_q <= prod_q[2*CW-1:0];
        else if (sel != 2'd0) dist_q <= dist_q + prod_q[DW-1:0];
      end
      default: ;
    endcase
    if (cmd_i.out_load) begin
      hit_o       <= hit;
      contact_x_o <= hit ? ct_sat[0] : '0;
      contact_y_o <= hit ? ct_sat[1] : '0;
      contact_z_o <= hit ? ct_sat[2] : '0;
    end
  end

endmodule
`default_nettype wire
